### rtl/ifrf_pkg.sv
package ifrf_pkg;

  // Screen geometry
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 200;
  localparam int FRAME_SIZE    = SCREEN_WIDTH * SCREEN_HEIGHT;

  localparam int ADDR_W = (FRAME_SIZE > 1) ? $clog2(FRAME_SIZE) : 1;
  localparam int XW     = $clog2(SCREEN_WIDTH + 1);
  localparam int YW     = $clog2(SCREEN_HEIGHT + 1);

  // Palette
  localparam int PAL_DEPTH = 256;
  localparam int PAL_AW    = 8;
  localparam int COMP_W    = 6;
  localparam int PAL_W     = 3 * COMP_W;

  // Reset clearing pass covers both stores
  localparam int INIT_LEN = (FRAME_SIZE > PAL_DEPTH) ? FRAME_SIZE : PAL_DEPTH;
  localparam int INIT_W   = $clog2(INIT_LEN);

  // Queues
  localparam int CMD_DEPTH  = 4;
  localparam int CMD_PW     = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W  = $clog2(CMD_DEPTH + 1);
  localparam int OUT_DEPTH  = 4;
  localparam int OUT_PW     = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);

  // Command kinds
  localparam logic [2:0] KIND_PUT   = 3'd0;
  localparam logic [2:0] KIND_FILL  = 3'd1;
  localparam logic [2:0] KIND_CLEAR = 3'd2;
  localparam logic [2:0] KIND_PAL   = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;

  typedef enum logic [1:0] {
    JOB_FILL = 2'd0,
    JOB_PAL  = 2'd1,
    JOB_READ = 2'd2
  } job_op_t;

  // Classified command after clipping
  typedef struct packed {
    job_op_t           op;
    logic [7:0]        color;
    logic [PAL_W-1:0]  rgb;
    logic [XW-1:0]     x0;
    logic [YW-1:0]     y0;
    logic [XW-1:0]     span;
    logic [YW-1:0]     rows;
    logic              in_range;
  } clip_t;

  // Job handed to the back end
  typedef struct packed {
    job_op_t           op;
    logic [7:0]        color;
    logic [PAL_W-1:0]  rgb;
    logic [ADDR_W-1:0] addr;
    logic [XW-1:0]     span;
    logic [YW-1:0]     rows;
    logic              in_range;
  } job_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       in_range;
  } res_t;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

  // c*255/63 = 4c + c/21, since 255 = 4*63 + 3
  function automatic logic [7:0] expand6(input logic [COMP_W-1:0] c);
    logic [1:0] q;
    begin
      if (c >= 6'd63)      q = 2'd3;
      else if (c >= 6'd42) q = 2'd2;
      else if (c >= 6'd21) q = 2'd1;
      else                 q = 2'd0;
      expand6 = {c, 2'b00} + {6'd0, q};
    end
  endfunction

endpackage

### rtl/ifrf_front.sv
module ifrf_front import ifrf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               hold,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         in_kind,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_rect_width,
  input  logic signed [15:0] in_rect_height,
  input  logic [7:0]         in_color,
  input  logic [5:0]         in_red,
  input  logic [5:0]         in_green,
  input  logic [5:0]         in_blue,
  output logic               job_push,
  input  logic               job_full,
  output job_t               job
);

  localparam logic signed [17:0] W_S = 18'(SCREEN_WIDTH);
  localparam logic signed [17:0] H_S = 18'(SCREEN_HEIGHT);

  logic              s1_v_r, s1_v_nxt, s2_v_r, s2_v_nxt;
  clip_t             s1_r, s1_nxt;
  job_t              s2_r, s2_nxt;
  logic              accept, s2_take, cls_ok;
  logic signed [17:0] xs, ys, ws, hs, xe, ye, x0s, y0s, x1s, y1s, dx, dy;
  logic              on_scr, fill_ok;
  logic [ADDR_W-1:0] row_addr;

  // Sign-extend and clip
  always_comb begin
    xs  = {{2{in_pos_x[15]}}, in_pos_x};
    ys  = {{2{in_pos_y[15]}}, in_pos_y};
    ws  = {{2{in_rect_width[15]}}, in_rect_width};
    hs  = {{2{in_rect_height[15]}}, in_rect_height};
    xe  = xs + ws;
    ye  = ys + hs;
    x0s = xs[17] ? 18'sd0 : xs;
    y0s = ys[17] ? 18'sd0 : ys;
    x1s = (xe > W_S) ? W_S : xe;
    y1s = (ye > H_S) ? H_S : ye;
    dx  = x1s - x0s;
    dy  = y1s - y0s;
    on_scr  = !xs[17] && (xs < W_S) && !ys[17] && (ys < H_S);
    fill_ok = (ws > 18'sd0) && (hs > 18'sd0) && (x0s < x1s) && (y0s < y1s);
  end

  // Classify the incoming command
  always_comb begin
    cls_ok          = 1'b0;
    s1_nxt.op       = JOB_FILL;
    s1_nxt.color    = in_color;
    s1_nxt.rgb      = {in_red, in_green, in_blue};
    s1_nxt.x0       = '0;
    s1_nxt.y0       = '0;
    s1_nxt.span     = XW'(1);
    s1_nxt.rows     = YW'(1);
    s1_nxt.in_range = on_scr;
    unique case (in_kind)
      KIND_PUT: begin
        cls_ok    = on_scr;
        s1_nxt.x0 = xs[XW-1:0];
        s1_nxt.y0 = ys[YW-1:0];
      end
      KIND_FILL: begin
        cls_ok      = fill_ok;
        s1_nxt.x0   = x0s[XW-1:0];
        s1_nxt.y0   = y0s[YW-1:0];
        s1_nxt.span = dx[XW-1:0];
        s1_nxt.rows = dy[YW-1:0];
      end
      KIND_CLEAR: begin
        cls_ok      = 1'b1;
        s1_nxt.span = XW'(SCREEN_WIDTH);
        s1_nxt.rows = YW'(SCREEN_HEIGHT);
      end
      KIND_PAL: begin
        cls_ok    = 1'b1;
        s1_nxt.op = JOB_PAL;
      end
      KIND_READ: begin
        cls_ok    = 1'b1;
        s1_nxt.op = JOB_READ;
        if (on_scr) begin
          s1_nxt.x0 = xs[XW-1:0];
          s1_nxt.y0 = ys[YW-1:0];
        end
      end
      default: cls_ok = 1'b0;
    endcase
  end

  // Stage handshakes
  assign job_push = s2_v_r && !job_full;
  assign s2_take  = !s2_v_r || !job_full;
  assign full     = hold || (s1_v_r && !s2_take);
  assign accept   = push && !full;
  assign job      = s2_r;

  // Row start address: one constant multiply
  assign row_addr = ADDR_W'(ADDR_W'(s1_r.y0) * ADDR_W'(SCREEN_WIDTH));

  always_comb begin
    s2_nxt.op       = s1_r.op;
    s2_nxt.color    = s1_r.color;
    s2_nxt.rgb      = s1_r.rgb;
    s2_nxt.addr     = row_addr + ADDR_W'(s1_r.x0);
    s2_nxt.span     = s1_r.span;
    s2_nxt.rows     = s1_r.rows;
    s2_nxt.in_range = s1_r.in_range;
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept)                s1_v_nxt = cls_ok;
    else if (s1_v_r && s2_take) s1_v_nxt = 1'b0;
    s2_v_nxt = s2_v_r;
    if (s2_take) s2_v_nxt = s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  // Payload stages carry no reset
  always_ff @(posedge clk) begin
    if (accept) s1_r <= s1_nxt;
    if (s2_take && s1_v_r) s2_r <= s2_nxt;
  end

endmodule

### rtl/ifrf_cmd_fifo.sv
module ifrf_cmd_fifo import ifrf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  job_t wr_job,
  input  logic pop,
  output logic empty,
  output job_t rd_job
);

  job_t                 mem_r [CMD_DEPTH];
  logic [CMD_PW-1:0]    wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CMD_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign full    = (cnt_r == CMD_CNT_W'(CMD_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = mem_r[rptr_r];

  // Advance pointers and count
  always_comb begin
    wptr_nxt = do_push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + CMD_CNT_W'(do_push) - CMD_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= wr_job;
  end

endmodule

### rtl/ifrf_back.sv
module ifrf_back import ifrf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       job_empty,
  input  job_t       job,
  output logic       job_pop,
  output back_stat_t stat,
  output logic       res_empty,
  output res_t       res,
  input  logic       res_pop
);

  typedef enum logic [2:0] {
    ST_INIT = 3'b001,
    ST_IDLE = 3'b010,
    ST_FILL = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [INIT_W-1:0]   clr_cnt_r, clr_cnt_nxt;

  // Sweep registers
  logic [ADDR_W-1:0]   addr_r, addr_nxt, base_r, base_nxt;
  logic [XW-1:0]       cols_r, cols_nxt, span_r, span_nxt;
  logic [YW-1:0]       rows_r, rows_nxt;
  logic [7:0]          color_r, color_nxt;
  logic [ADDR_W-1:0]   cur_addr, cur_base;
  logic [XW-1:0]       cur_cols, cur_span;
  logic [YW-1:0]       cur_rows;
  logic [7:0]          cur_color;
  logic                in_fill, fill_go, last_col, last_px;

  // Memories
  logic [7:0]          frame_mem [FRAME_SIZE];
  logic [PAL_W-1:0]    pal_mem [PAL_DEPTH];
  logic                frame_we, frame_re, pal_we;
  logic [ADDR_W-1:0]   frame_waddr;
  logic [7:0]          frame_wdata, frame_q_r;
  logic [PAL_AW-1:0]   pal_waddr;
  logic [PAL_W-1:0]    pal_wdata, pal_q_r;

  // Read pipeline
  logic                rd1_v_r, rd1_v_nxt, rd2_v_r;
  logic                rd1_inr_r, rd1_inr_nxt, rd2_inr_r;
  logic [OUT_CNT_W:0]  used;
  logic                can_read;

  // Result queue
  res_t                ofifo_r [OUT_DEPTH];
  logic [OUT_PW-1:0]   owptr_r, owptr_nxt, orptr_r, orptr_nxt;
  logic [OUT_CNT_W-1:0] ocnt_r, ocnt_nxt;
  logic                o_push, o_pop;
  res_t                o_data;

  assign stat.init_busy = (state_r == ST_INIT);

  // Space left for a read, counting reads still in flight
  assign used = {1'b0, ocnt_r} + (OUT_CNT_W+1)'(rd1_v_r) + (OUT_CNT_W+1)'(rd2_v_r);
  assign can_read = (used < (OUT_CNT_W+1)'(OUT_DEPTH));

  // Current sweep position: from the job on its first pixel, else from registers
  assign in_fill   = (state_r == ST_FILL);
  assign cur_addr  = in_fill ? addr_r  : job.addr;
  assign cur_base  = in_fill ? base_r  : job.addr;
  assign cur_cols  = in_fill ? cols_r  : job.span;
  assign cur_span  = in_fill ? span_r  : job.span;
  assign cur_rows  = in_fill ? rows_r  : job.rows;
  assign cur_color = in_fill ? color_r : job.color;
  assign last_col  = (cur_cols == XW'(1));
  assign last_px   = last_col && (cur_rows == YW'(1));

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    addr_nxt    = addr_r;
    base_nxt    = base_r;
    cols_nxt    = cols_r;
    rows_nxt    = rows_r;
    span_nxt    = span_r;
    color_nxt   = color_r;
    job_pop     = 1'b0;
    fill_go     = 1'b0;
    frame_we    = 1'b0;
    frame_re    = 1'b0;
    frame_waddr = cur_addr;
    frame_wdata = cur_color;
    pal_we      = 1'b0;
    pal_waddr   = job.color;
    pal_wdata   = job.rgb;
    rd1_v_nxt   = 1'b0;
    rd1_inr_nxt = job.in_range;
    unique case (state_r)
      ST_INIT: begin
        frame_we    = (clr_cnt_r < FRAME_SIZE);
        frame_waddr = clr_cnt_r[ADDR_W-1:0];
        frame_wdata = '0;
        pal_we      = (clr_cnt_r < PAL_DEPTH);
        pal_waddr   = clr_cnt_r[PAL_AW-1:0];
        pal_wdata   = '0;
        if (clr_cnt_r == INIT_W'(INIT_LEN - 1)) state_nxt = ST_IDLE;
        else clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      ST_IDLE: begin
        if (!job_empty) begin
          case (job.op)
            JOB_FILL: begin
              job_pop = 1'b1;
              fill_go = 1'b1;
            end
            JOB_PAL: begin
              job_pop = 1'b1;
              pal_we  = 1'b1;
            end
            JOB_READ: begin
              if (can_read) begin
                job_pop   = 1'b1;
                frame_re  = job.in_range;
                rd1_v_nxt = 1'b1;
              end
            end
            default: job_pop = 1'b1;
          endcase
        end
      end
      ST_FILL: fill_go = 1'b1;
      default: state_nxt = ST_IDLE;
    endcase
    // Write one pixel and step along the row, or to the next row
    if (fill_go) begin
      frame_we  = 1'b1;
      span_nxt  = cur_span;
      color_nxt = cur_color;
      if (last_px) begin
        state_nxt = ST_IDLE;
      end else if (last_col) begin
        state_nxt = ST_FILL;
        base_nxt  = cur_base + ADDR_W'(SCREEN_WIDTH);
        addr_nxt  = cur_base + ADDR_W'(SCREEN_WIDTH);
        cols_nxt  = cur_span;
        rows_nxt  = cur_rows - 1'b1;
      end else begin
        state_nxt = ST_FILL;
        base_nxt  = cur_base;
        addr_nxt  = cur_addr + 1'b1;
        cols_nxt  = cur_cols - 1'b1;
        rows_nxt  = cur_rows;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_INIT;
      clr_cnt_r <= '0;
      rd1_v_r   <= 1'b0;
      rd2_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      rd1_v_r   <= rd1_v_nxt;
      rd2_v_r   <= rd1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    base_r    <= base_nxt;
    cols_r    <= cols_nxt;
    rows_r    <= rows_nxt;
    span_r    <= span_nxt;
    color_r   <= color_nxt;
    rd1_inr_r <= rd1_inr_nxt;
    rd2_inr_r <= rd1_inr_r;
  end

  // Frame store
  always_ff @(posedge clk) begin
    if (frame_we) frame_mem[frame_waddr] <= frame_wdata;
    if (frame_re) frame_q_r <= frame_mem[cur_addr];
  end

  // Palette store, looked up with the registered pixel index
  always_ff @(posedge clk) begin
    if (pal_we) pal_mem[pal_waddr] <= pal_wdata;
    if (rd1_v_r) pal_q_r <= pal_mem[frame_q_r];
  end

  // Expand and queue the result; off-screen reads give zeros
  always_comb begin
    o_data.red      = rd2_inr_r ? expand6(pal_q_r[3*COMP_W-1:2*COMP_W]) : 8'd0;
    o_data.green    = rd2_inr_r ? expand6(pal_q_r[2*COMP_W-1:COMP_W]) : 8'd0;
    o_data.blue     = rd2_inr_r ? expand6(pal_q_r[COMP_W-1:0]) : 8'd0;
    o_data.in_range = rd2_inr_r;
  end

  assign o_push    = rd2_v_r;
  assign res_empty = (ocnt_r == '0);
  assign o_pop     = res_pop && !res_empty;
  assign res       = ofifo_r[orptr_r];

  always_comb begin
    owptr_nxt = o_push ? owptr_r + 1'b1 : owptr_r;
    orptr_nxt = o_pop ? orptr_r + 1'b1 : orptr_r;
    ocnt_nxt  = ocnt_r + OUT_CNT_W'(o_push) - OUT_CNT_W'(o_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owptr_r <= '0;
      orptr_r <= '0;
      ocnt_r  <= '0;
    end else begin
      owptr_r <= owptr_nxt;
      orptr_r <= orptr_nxt;
      ocnt_r  <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (o_push) ofifo_r[owptr_r] <= o_data;
  end

  // Checks
  a_ocnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= OUT_CNT_W'(OUT_DEPTH))
    else $error("result queue count beyond depth");

  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    rd2_v_r |-> (ocnt_r < OUT_CNT_W'(OUT_DEPTH)))
    else $error("read reached a full result queue");

  a_no_job_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INIT) |-> !job_pop)
    else $error("job taken during clearing pass");

  a_rw_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(frame_we && frame_re))
    else $error("frame store read and written in one cycle");

endmodule

### rtl/indexed_framebuffer_rect_fill_unit.sv
// Indexed-colour frame store with a 256-entry palette and rectangle fill.
// Commands enter through a queue port: push with full, taken at an edge with
// push high and full low. Kinds: put pixel, fill rectangle, clear frame, load
// palette entry, read pixel. Only a read gives a result, presented through a
// second queue port: the oldest result is on out_* while empty is low and is
// taken at an edge with pop high and empty low.
// Commands are clipped in a two-stage front end and handed over a four-entry
// job queue to the back end, which owns the frame and palette memories.
// The back end does a put, palette load or read from the idle state; a fill
// or a clear writes one covered pixel per cycle (a clear covers 64000). A read
// result is registered by the frame store read and the palette lookup.
// After reset the back end clears both stores, one frame entry a cycle and,
// for the first 256, one palette entry a cycle; full stays high throughout.
// Results wait in a four-entry queue; when the receiver stalls, reads stop
// issuing once it is spoken for, a blocked read holds back later jobs until
// the job queue backs up, and then full rises.
module indexed_framebuffer_rect_fill_unit import ifrf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         in_kind,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_rect_width,
  input  logic signed [15:0] in_rect_height,
  input  logic [7:0]         in_color,
  input  logic [5:0]         in_red,
  input  logic [5:0]         in_green,
  input  logic [5:0]         in_blue,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic               out_in_range
);

  job_t       fe_job, q_job;
  logic       fe_push, q_full, q_pop, q_empty;
  back_stat_t be_stat;
  res_t       res;

  ifrf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .hold           (be_stat.init_busy),
    .push           (push),
    .full           (full),
    .in_kind        (in_kind),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .in_color       (in_color),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .job_push       (fe_push),
    .job_full       (q_full),
    .job            (fe_job)
  );

  ifrf_cmd_fifo u_cmd_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (fe_push),
    .full   (q_full),
    .wr_job (fe_job),
    .pop    (q_pop),
    .empty  (q_empty),
    .rd_job (q_job)
  );

  ifrf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (q_empty),
    .job       (q_job),
    .job_pop   (q_pop),
    .stat      (be_stat),
    .res_empty (empty),
    .res       (res),
    .res_pop   (pop)
  );

  assign out_red      = res.red;
  assign out_green    = res.green;
  assign out_blue     = res.blue;
  assign out_in_range = res.in_range;

endmodule

### tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ifrf_pkg::*;

  // Kinds the block must ignore
  localparam logic [2:0] KIND_FIRST_SPARE = 3'd5;
  localparam logic [2:0] KIND_LAST_SPARE  = 3'd7;

  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int RANDOM_CMDS   = 1500;
  localparam int CALM_TAIL     = 200;
  localparam int SETTLE_CYCLES = 64;

  typedef struct {
    logic [2:0]         kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] w;
    logic signed [15:0] h;
    logic [7:0]         color;
    logic [5:0]         red;
    logic [5:0]         green;
    logic [5:0]         blue;
  } draw_cmd_t;

  logic               clk;
  logic               rst_n;
  logic               push;
  logic               full;
  logic [2:0]         in_kind;
  logic signed [15:0] in_pos_x;
  logic signed [15:0] in_pos_y;
  logic signed [15:0] in_rect_width;
  logic signed [15:0] in_rect_height;
  logic [7:0]         in_color;
  logic [5:0]         in_red;
  logic [5:0]         in_green;
  logic [5:0]         in_blue;
  logic               empty;
  logic               pop;
  logic [7:0]         out_red;
  logic [7:0]         out_green;
  logic [7:0]         out_blue;
  logic               out_in_range;

  // Mirror of the frame and palette stores
  logic [7:0]       frame_mirror [0:FRAME_SIZE-1];
  logic [PAL_W-1:0] palette_mirror [0:PAL_DEPTH-1];
  res_t             pending_reads [$];

  int  mismatches;
  int  cycle_count;
  bit  idling_on;

  indexed_framebuffer_rect_fill_unit DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_kind       (in_kind),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_rect_width (in_rect_width),
    .in_rect_height(in_rect_height),
    .in_color      (in_color),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .empty         (empty),
    .pop           (pop),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_in_range  (out_in_range)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit on_screen(input int x, input int y);
    return x >= 0 && y >= 0 && x < SCREEN_WIDTH && y < SCREEN_HEIGHT;
  endfunction

  // Scale a 6-bit component to the full 8-bit range, truncating
  function automatic logic [7:0] widen_comp(input logic [5:0] c);
    return 8'((int'(c) * 255) / 63);
  endfunction

  function automatic draw_cmd_t make_cmd(input logic [2:0] kind, input int x, input int y,
                                         input int w, input int h, input int col);
    draw_cmd_t c;
    c.kind  = kind;
    c.x     = 16'(x);
    c.y     = 16'(y);
    c.w     = 16'(w);
    c.h     = 16'(h);
    c.color = 8'(col);
    c.red   = 6'($urandom);
    c.green = 6'($urandom);
    c.blue  = 6'($urandom);
    return c;
  endfunction

  task automatic note_mismatch(input string what, input logic [7:0] want, input logic [7:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
  endtask

  // Offer one command, hold it until the transfer, then update the mirror
  task automatic send_cmd(input draw_cmd_t c);
    int gap, xi, yi, wi, hi, x0, y0, x1, y1;
    logic [7:0] idx;
    res_t want;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push           <= 1'b1;
    in_kind        <= c.kind;
    in_pos_x       <= c.x;
    in_pos_y       <= c.y;
    in_rect_width  <= c.w;
    in_rect_height <= c.h;
    in_color       <= c.color;
    in_red         <= c.red;
    in_green       <= c.green;
    in_blue        <= c.blue;
    @(posedge clk);
    while (full) @(posedge clk);

    xi = c.x;
    yi = c.y;
    wi = c.w;
    hi = c.h;
    case (c.kind)
      KIND_PUT: begin
        if (on_screen(xi, yi)) begin
          frame_mirror[yi * SCREEN_WIDTH + xi] = c.color;
        end
      end
      KIND_FILL: begin
        // Clip the rectangle to the screen; wide origins must not wrap
        x0 = (xi < 0) ? 0 : xi;
        y0 = (yi < 0) ? 0 : yi;
        x1 = xi + wi;
        y1 = yi + hi;
        if (x1 > SCREEN_WIDTH)  x1 = SCREEN_WIDTH;
        if (y1 > SCREEN_HEIGHT) y1 = SCREEN_HEIGHT;
        if (wi > 0 && hi > 0 && x0 < x1 && y0 < y1) begin
          for (int r = y0; r < y1; r++)
            for (int col = x0; col < x1; col++)
              frame_mirror[r * SCREEN_WIDTH + col] = c.color;
        end
      end
      KIND_CLEAR: begin
        for (int i = 0; i < FRAME_SIZE; i++) frame_mirror[i] = c.color;
      end
      KIND_PAL: begin
        palette_mirror[c.color] = {c.red, c.green, c.blue};
      end
      KIND_READ: begin
        want = '0;
        if (on_screen(xi, yi)) begin
          idx            = frame_mirror[yi * SCREEN_WIDTH + xi];
          want.red       = widen_comp(palette_mirror[idx][17:12]);
          want.green     = widen_comp(palette_mirror[idx][11:6]);
          want.blue      = widen_comp(palette_mirror[idx][5:0]);
          want.in_range  = 1'b1;
        end
        pending_reads.push_back(want);
      end
      default: ;
    endcase
  endtask

  task automatic read_at(input int x, input int y);
    send_cmd(make_cmd(KIND_READ, x, y, $urandom, $urandom, $urandom));
  endtask

  task automatic load_palette(input int entry, input int r, input int g, input int b);
    draw_cmd_t c;
    c       = make_cmd(KIND_PAL, $urandom, $urandom, $urandom, $urandom, entry);
    c.red   = 6'(r);
    c.green = 6'(g);
    c.blue  = 6'(b);
    send_cmd(c);
  endtask

  // Reset contents, palette expansion edges, corner and off-screen pixels
  task automatic test_points_and_palette;
    read_at(0, 0);
    load_palette(255, 63, 63, 63);
    load_palette(1, 21, 42, 20);
    load_palette(128, 62, 41, 0);
    send_cmd(make_cmd(KIND_PUT, 0, 0, 0, 0, 255));
    send_cmd(make_cmd(KIND_PUT, 319, 199, 0, 0, 1));
    send_cmd(make_cmd(KIND_PUT, -32768, 32767, 0, 0, 1));
    send_cmd(make_cmd(KIND_PUT, 320, 5, 0, 0, 1));
    read_at(0, 0);
    read_at(319, 199);
    read_at(320, 5);
    read_at(-1, 0);
    read_at(0, 200);
  endtask

  // Partly off-screen, empty and wrap-prone rectangles
  task automatic test_fill_clipping;
    send_cmd(make_cmd(KIND_FILL, -3, -2, 6, 5, 128));
    send_cmd(make_cmd(KIND_FILL, 317, 197, 32767, 32767, 1));
    send_cmd(make_cmd(KIND_FILL, 10, 10, 0, 4, 255));
    send_cmd(make_cmd(KIND_FILL, 10, 10, 4, -32768, 255));
    send_cmd(make_cmd(KIND_FILL, 32767, 0, 32767, 1, 255));
    send_cmd(make_cmd(KIND_FILL, -32768, 10, 32767, 1, 255));
    read_at(2, 2);
    read_at(317, 197);
    read_at(10, 10);
  endtask

  // Unused kinds must neither write nor answer
  task automatic test_spare_kinds;
    for (int k = KIND_FIRST_SPARE; k <= KIND_LAST_SPARE; k++)
      send_cmd(make_cmd(3'(k), 2, 2, 3, 3, 0));
    read_at(2, 2);
  endtask

  task automatic test_clear_frame;
    send_cmd(make_cmd(KIND_CLEAR, $urandom, $urandom, $urandom, $urandom, 255));
    read_at(160, 100);
  endtask

  // Traffic around a moving hot window so reads land on written pixels
  task automatic test_random_traffic(input int target);
    int n, pick, sub, hx, hy, x, y, w, h, col, clears_left, bigs_left;
    logic [2:0] kind;
    n           = 0;
    hx          = 0;
    hy          = 0;
    clears_left = 3;
    bigs_left   = 4;
    while (n < target) begin
      if (n % 64 == 0) begin
        idling_on = (n < target - CALM_TAIL) && ($urandom_range(0, 3) != 0);
        hx = int'($urandom_range(0, 320)) - 8;
        hy = int'($urandom_range(0, 200)) - 8;
      end
      n++;
      x    = hx + int'($urandom_range(0, 15));
      y    = hy + int'($urandom_range(0, 15));
      w    = $urandom;
      h    = $urandom;
      col  = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 255);
      kind = KIND_READ;
      pick = $urandom_range(0, 99);
      if (pick < 24) begin
        kind = KIND_PUT;
      end else if (pick < 56) begin
        kind = KIND_READ;
      end else if (pick < 70) begin
        kind = KIND_FILL;
        x    = hx + int'($urandom_range(0, 19)) - 4;
        y    = hy + int'($urandom_range(0, 19)) - 4;
        w    = int'($urandom_range(0, 14)) - 2;
        h    = int'($urandom_range(0, 14)) - 2;
      end else if (pick < 80) begin
        kind = KIND_PAL;
        col  = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 7) : $urandom_range(0, 255);
      end else if (pick < 97) begin
        sub = $urandom_range(0, 4);
        case (sub)
          0: begin
            kind = KIND_PUT;
            x    = $urandom;
            y    = $urandom;
          end
          1: begin
            kind = KIND_READ;
            x    = $urandom;
            y    = $urandom;
          end
          2: begin
            // Any size, origin right of the screen: nothing lands
            kind = KIND_FILL;
            x    = $urandom_range(320, 32767);
            y    = $urandom;
          end
          3: begin
            // Far-left origin with a huge width leaving a thin strip
            kind = KIND_FILL;
            x    = -int'($urandom_range(1000, 32000));
            w    = -x + int'($urandom_range(1, 12));
            h    = $urandom_range(1, 6);
            if ($urandom_range(0, 1)) begin
              y = -int'($urandom_range(1000, 32000));
              h = -y + int'($urandom_range(1, 6));
            end
          end
          default: kind = 3'($urandom_range(KIND_FIRST_SPARE, KIND_LAST_SPARE));
        endcase
      end else if (clears_left > 0 && $urandom_range(0, 1)) begin
        kind = KIND_CLEAR;
        col  = $urandom_range(0, 255);
        clears_left--;
      end else if (bigs_left > 0) begin
        kind = KIND_FILL;
        x    = int'($urandom_range(0, 500)) - 200;
        y    = int'($urandom_range(0, 400)) - 200;
        w    = $urandom_range(100, 400);
        h    = $urandom_range(100, 400);
        bigs_left--;
      end
      send_cmd(make_cmd(kind, x, y, w, h, col));
    end
  endtask

  // Finish on a read so everything before it has been written back
  task automatic test_drain;
    idling_on = 1'b0;
    read_at($urandom_range(0, SCREEN_WIDTH - 1), $urandom_range(0, SCREEN_HEIGHT - 1));
    push <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver side: pop with random stall bursts
  initial begin
    forever begin
      if (idling_on && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
    end
  end

  // Check every result transfer against the oldest pending read
  always @(posedge clk) begin
    res_t want;
    if (rst_n && pop && !empty) begin
      if (pending_reads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no read pending: %0d %0d %0d range %0d", $realtime,
                   out_red, out_green, out_blue, out_in_range);
      end else begin
        want = pending_reads.pop_front();
        if (out_red !== want.red)            note_mismatch("red", want.red, out_red);
        if (out_green !== want.green)        note_mismatch("green", want.green, out_green);
        if (out_blue !== want.blue)          note_mismatch("blue", want.blue, out_blue);
        if (out_in_range !== want.in_range)
          note_mismatch("in_range", 8'(want.in_range), 8'(out_in_range));
      end
    end
  end

  // Watchdog; covers the clearing pass, clears and large fills with margin
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    mismatches     = 0;
    cycle_count    = 0;
    idling_on      = 1'b1;
    for (int i = 0; i < FRAME_SIZE; i++) frame_mirror[i] = '0;
    for (int i = 0; i < PAL_DEPTH; i++)  palette_mirror[i] = '0;
    rst_n          <= 1'b0;
    push           <= 1'b0;
    in_kind        <= KIND_PUT;
    in_pos_x       <= '0;
    in_pos_y       <= '0;
    in_rect_width  <= '0;
    in_rect_height <= '0;
    in_color       <= '0;
    in_red         <= '0;
    in_green       <= '0;
    in_blue        <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_points_and_palette();
    test_fill_clipping();
    test_spare_kinds();
    test_clear_frame();
    test_random_traffic(RANDOM_CMDS);
    test_drain();

    if (mismatches == 0 && pending_reads.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
